### sv/rpdd_pkg.sv
// Shared types, constants and hash function for the read pair duplicate detector.
package rpdd_pkg;
  localparam int unsigned SetSlots = 16384;
  localparam int unsigned FieldW = 31;
  localparam int unsigned SigW = 128;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } sig_t;

  function automatic logic [63:0] make_part(input logic rev, input logic [30:0] tid,
                                            input logic [30:0] coord);
    make_part = {1'b0, coord, tid, rev};
  endfunction

  function automatic logic [31:0] sig_hash(input sig_t s);
    logic [31:0] a;
    a = {s.hi[0], s.lo[63:33]};
    sig_hash = a ^ s.lo[31:0] ^ {s.lo[20:0], 11'b0};
  endfunction
endpackage

### sv/rpdd_front.sv
// Front end: accepts read pairs, builds the ordered signature and home slot, queues them.
module rpdd_front #(
  parameter int unsigned SET_SLOTS = rpdd_pkg::SetSlots,
  localparam int unsigned IdxW = $clog2(SET_SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             first_reverse,
  input  logic [30:0]      first_tid,
  input  logic [30:0]      first_start,
  input  logic [30:0]      first_end,
  input  logic             second_reverse,
  input  logic [30:0]      second_tid,
  input  logic [30:0]      second_start,
  input  logic [30:0]      second_end,
  output logic             q_valid,
  output rpdd_pkg::sig_t   q_sig,
  output logic [IdxW-1:0]  q_home,
  input  logic             q_pop
);
  localparam int unsigned QD = rpdd_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(QD);

  rpdd_pkg::sig_t  qsig [QD];
  logic [IdxW-1:0] qhome [QD];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0]   count;

  logic [30:0]     fpos, spos;
  logic            first_low;
  rpdd_pkg::sig_t  sig;
  logic [31:0]     h;
  logic            push;

  always_comb begin
    fpos = first_reverse ? first_end : first_start;
    spos = second_reverse ? second_end : second_start;
    first_low = (first_tid == second_tid) ? (fpos < spos) : (first_tid < second_tid);
    if (first_low) begin
      sig.lo = rpdd_pkg::make_part(first_reverse, first_tid, fpos);
      sig.hi = rpdd_pkg::make_part(second_reverse, second_tid, spos);
    end else begin
      sig.lo = rpdd_pkg::make_part(second_reverse, second_tid, spos);
      sig.hi = rpdd_pkg::make_part(first_reverse, first_tid, fpos);
    end
    h = rpdd_pkg::sig_hash(sig);
  end

  assign busy    = (count == (PtrW+1)'(QD));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_sig   = qsig[rptr];
  assign q_home  = qhome[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qsig[wptr]  <= sig;
      qhome[wptr] <= IdxW'(h % 32'(SET_SLOTS));
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PtrW'(QD-1)) ? '0 : wptr + 1'b1;
      if (q_pop) rptr <= (rptr == PtrW'(QD-1)) ? '0 : rptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule

### sv/rpdd_back.sv
// Back end: triangular probing of the hash set held in memory, with clearing pass after reset.
module rpdd_back #(
  parameter int unsigned SET_SLOTS = rpdd_pkg::SetSlots,
  localparam int unsigned IdxW = $clog2(SET_SLOTS),
  localparam int unsigned CntW = $clog2(SET_SLOTS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rpdd_pkg::sig_t  q_sig,
  input  logic [IdxW-1:0] q_home,
  output logic            q_pop,
  output logic            done,
  output logic            is_duplicate,
  output logic            table_full
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CntW-1:0] Slots = CntW'(SET_SLOTS);

  logic [SET_SLOTS > 0 ? rpdd_pkg::SigW : 1:0] mem [SET_SLOTS];
  logic [rpdd_pkg::SigW:0] rd;
  logic [2:0]      state;
  logic [IdxW-1:0] idx, clr;
  logic [CntW-1:0] step;
  rpdd_pkg::sig_t  sig;
  logic [CntW:0]   sum;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [rpdd_pkg::SigW:0] wr_data;

  assign sum   = (CntW+1)'(idx) + (CntW+1)'(step);
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = {1'b1, sig};
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr;
      wr_data = '0;
    end else if (state == S_CHECK && !rd[rpdd_pkg::SigW]) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      idx   <= '0;
      is_duplicate <= 1'b0;
      table_full   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IdxW'(SET_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            sig   <= q_sig;
            idx   <= q_home;
            step  <= CntW'(1);
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (!rd[rpdd_pkg::SigW]) begin
            is_duplicate <= 1'b0;
            table_full   <= 1'b0;
            state <= S_DONE;
          end else if (rd[rpdd_pkg::SigW-1:0] == sig) begin
            is_duplicate <= 1'b1;
            table_full   <= 1'b0;
            state <= S_DONE;
          end else if (step == Slots) begin
            is_duplicate <= 1'b0;
            table_full   <= 1'b1;
            state <= S_DONE;
          end else begin
            // advance by the probe count, wrap once
            idx  <= (sum >= (CntW+1)'(SET_SLOTS)) ? IdxW'(sum - (CntW+1)'(SET_SLOTS))
                                                  : IdxW'(sum);
            step <= step + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/read_pair_duplicate_detector.sv
// Probing handles one pair at a time as a signature memory read then compare
// loop; a two-entry request queue decouples intake from probing.
// Reset: a clearing pass sweeps all SET_SLOTS memory entries; requests queue meanwhile.
// Results appear for one cycle with done; the receiver cannot stall.
// Set full: is_duplicate low and table_full high, nothing stored.
module read_pair_duplicate_detector #(
  parameter int unsigned SET_SLOTS = rpdd_pkg::SetSlots,
  localparam int unsigned IdxW = $clog2(SET_SLOTS)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        first_reverse,
  input  logic [30:0] first_tid,
  input  logic [30:0] first_start,
  input  logic [30:0] first_end,
  input  logic        second_reverse,
  input  logic [30:0] second_tid,
  input  logic [30:0] second_start,
  input  logic [30:0] second_end,
  output logic        done,
  output logic        is_duplicate,
  output logic        table_full
);
  logic            q_valid, q_pop;
  rpdd_pkg::sig_t  q_sig;
  logic [IdxW-1:0] q_home;

  rpdd_front #(.SET_SLOTS(SET_SLOTS)) u_front (
    .clk, .rst, .start, .busy,
    .first_reverse, .first_tid, .first_start, .first_end,
    .second_reverse, .second_tid, .second_start, .second_end,
    .q_valid, .q_sig, .q_home, .q_pop
  );

  rpdd_back #(.SET_SLOTS(SET_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_sig, .q_home, .q_pop,
    .done, .is_duplicate, .table_full
  );
endmodule

### dv/read_pair_duplicate_detector_tb.sv
// Testbench for the read pair duplicate detector: directed table and random pairs.
module read_pair_duplicate_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned RandomPairs = 1830;
  localparam int unsigned PoolMax = 256;

  typedef struct {
    bit        frev;
    bit [30:0] ftid;
    bit [30:0] fst;
    bit [30:0] fend;
    bit        srev;
    bit [30:0] stid;
    bit [30:0] sst;
    bit [30:0] s_end;
  } pair_t;

  typedef struct {
    bit dup;
    bit full;
  } verdict_t;

  typedef struct {
    pair_t pr;
    bit    known;
    bit    dup;
    bit    full;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        first_reverse;
  logic [30:0] first_tid;
  logic [30:0] first_start;
  logic [30:0] first_end;
  logic        second_reverse;
  logic [30:0] second_tid;
  logic [30:0] second_start;
  logic [30:0] second_end;
  logic        done;
  logic        is_duplicate;
  logic        table_full;

  read_pair_duplicate_detector dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_reverse(first_reverse), .first_tid(first_tid),
    .first_start(first_start), .first_end(first_end),
    .second_reverse(second_reverse), .second_tid(second_tid),
    .second_start(second_start), .second_end(second_end),
    .done(done), .is_duplicate(is_duplicate), .table_full(table_full)
  );

  // Predictor state: the signature set as the block should hold it.
  logic [127:0] sig_store [rpdd_pkg::SetSlots];
  bit           slot_taken [rpdd_pkg::SetSlots];

  verdict_t    verdicts_due[$];
  pair_t       seen_pairs[$];
  int unsigned errors;
  int unsigned cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic verdict_t lookup_pair(input pair_t p);
    logic [30:0]  fpos, spos;
    logic [63:0]  fpart, spart;
    logic [63:0]  lo, hi;
    logic [31:0]  h;
    int unsigned  idx;
    verdict_t     v;
    bit           first_low;
    fpos = p.frev ? p.fend : p.fst;
    spos = p.srev ? p.s_end : p.sst;
    first_low = (p.ftid == p.stid) ? (fpos < spos) : (p.ftid < p.stid);
    fpart = {1'b0, fpos, p.ftid, p.frev};
    spart = {1'b0, spos, p.stid, p.srev};
    lo = first_low ? fpart : spart;
    hi = first_low ? spart : fpart;
    h = {hi[0], lo[63:33]} ^ lo[31:0] ^ {lo[20:0], 11'b0};
    idx = h % rpdd_pkg::SetSlots;
    v = '{dup: 1'b0, full: 1'b1};
    for (int unsigned k = 1; k <= rpdd_pkg::SetSlots; k++) begin
      if (!slot_taken[idx]) begin
        slot_taken[idx] = 1'b1;
        sig_store[idx] = {hi, lo};
        v.full = 1'b0;
        break;
      end
      if (sig_store[idx] == {hi, lo}) begin
        v = '{dup: 1'b1, full: 1'b0};
        break;
      end
      idx = (idx + k) % rpdd_pkg::SetSlots;
    end
    return v;
  endfunction

  function automatic pair_t mk_pair(input int unsigned fr, input int unsigned ft,
                                    input int unsigned fs, input int unsigned fe,
                                    input int unsigned sr, input int unsigned st,
                                    input int unsigned ss, input int unsigned se);
    pair_t p;
    p = '{fr[0], ft[30:0], fs[30:0], fe[30:0], sr[0], st[30:0], ss[30:0], se[30:0]};
    return p;
  endfunction

  function automatic row_t mk_row(input pair_t p, input int unsigned known,
                                  input int unsigned dup, input int unsigned full);
    row_t r;
    r = '{pr: p, known: known[0], dup: dup[0], full: full[0]};
    return r;
  endfunction

  function automatic pair_t swap_reads(input pair_t p);
    return '{p.srev, p.stid, p.sst, p.s_end, p.frev, p.ftid, p.fst, p.fend};
  endfunction

  function automatic bit [30:0] rnd31();
    return 31'($urandom());
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 4 && seen_pairs.size() > 0) begin
      // Reuse a stored pair: swap reads, vary the coordinate that is not used, or flip the second strand.
      p = seen_pairs[$urandom_range(0, seen_pairs.size() - 1)];
      if ($urandom_range(0, 1)) p = swap_reads(p);
      if ($urandom_range(0, 1)) begin
        if (p.frev) p.fst = rnd31(); else p.fend = rnd31();
      end
      if ($urandom_range(0, 3) == 0) p.srev = ~p.srev;
    end else if (mode < 7) begin
      p = mk_pair($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 3),
                  $urandom_range(0, 15), $urandom_range(0, 15));
    end else begin
      p = '{1'($urandom_range(0, 1)), rnd31(), rnd31(), rnd31(),
            1'($urandom_range(0, 1)), rnd31(), rnd31(), rnd31()};
    end
    return p;
  endfunction

  // Caller is at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_pair(input pair_t p, input bit known, input bit dup, input bit full);
    verdict_t v;
    first_reverse  <= p.frev;
    first_tid      <= p.ftid;
    first_start    <= p.fst;
    first_end      <= p.fend;
    second_reverse <= p.srev;
    second_tid     <= p.stid;
    second_start   <= p.sst;
    second_end     <= p.s_end;
    start          <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    v = lookup_pair(p);
    if (known) v = '{dup: dup, full: full};
    verdicts_due.push_back(v);
    if (seen_pairs.size() < PoolMax) seen_pairs.push_back(p);
    else seen_pairs[$urandom_range(0, PoolMax - 1)] = p;
    @(negedge clk);
  endtask

  task automatic idle_gap(input bit allow_long);
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 92 || !allow_long) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdicts_due.size() > 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        e = verdicts_due.pop_front();
        if (is_duplicate !== e.dup)
          report($sformatf("is_duplicate %b, expected %b", is_duplicate, e.dup));
        if (table_full !== e.full)
          report($sformatf("table_full %b, expected %b", table_full, e.full));
      end
    end
  end

  initial begin
    row_t        rows[$];
    pair_t       p;
    int unsigned wait_cycles;
    bit          no_gaps;

    errors = 0;
    for (int i = 0; i < rpdd_pkg::SetSlots; i++) slot_taken[i] = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    {first_reverse, first_tid, first_start, first_end} = '0;
    {second_reverse, second_tid, second_start, second_end} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    rows.push_back(mk_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0));
    rows.push_back(mk_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0));
    rows.push_back(mk_row(mk_pair(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1, 0, 0));
    rows.push_back(mk_row(mk_pair(1, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
                                  1, 32'h7FFFFFFF, 0, 32'h7FFFFFFF), 1, 1, 0));
    rows.push_back(mk_row(mk_pair(0, 5, 100, 200, 1, 3, 50, 300), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(1, 3, 50, 300, 0, 5, 100, 200), 1, 1, 0));
    rows.push_back(mk_row(mk_pair(0, 5, 100, 999, 1, 3, 7, 300), 1, 1, 0));
    rows.push_back(mk_row(mk_pair(0, 7, 40, 1, 1, 7, 2, 40), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(1, 7, 2, 40, 0, 7, 40, 1), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(0, 7, 90, 0, 0, 7, 10, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(0, 7, 10, 0, 0, 7, 90, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(1, 9, 0, 0, 0, 2, 0, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(0, 9, 0, 0, 0, 2, 0, 0), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(0, 32'h55555555, 32'h2AAAAAAA, 32'h55555555,
                                  1, 32'h2AAAAAAA, 32'h55555555, 32'h2AAAAAAA), 0, 0, 0));
    rows.push_back(mk_row(mk_pair(1, 32'h2AAAAAAA, 32'h55555555, 32'h2AAAAAAA,
                                  0, 32'h55555555, 32'h2AAAAAAA, 32'h55555555), 0, 0, 0));
    foreach (rows[i]) begin
      issue_pair(rows[i].pr, rows[i].known, rows[i].dup, rows[i].full);
      idle_gap(1'b0);
    end

    // Hold off until every outstanding request has answered.
    drain();

    no_gaps = 1'b0;
    for (int i = 0; i < RandomPairs; i++) begin
      if (i % 200 == 0) no_gaps = $urandom_range(0, 2) == 0;
      p = random_pair();
      issue_pair(p, 1'b0, 1'b0, 1'b0);
      if (!no_gaps) idle_gap(1'b1);
    end
    drain();

    // Close with near ties on one reference, then a few more random pairs.
    for (int i = 0; i < 3; i++) begin
      p = mk_pair(0, 32'h3FFFFF00 + i, i, 0, 0, 32'h3FFFFF00 + i, i + 1, 0);
      issue_pair(p, 1'b0, 1'b0, 1'b0);
      idle_gap(1'b0);
    end
    for (int i = 0; i < 6; i++) begin
      issue_pair(random_pair(), 1'b0, 1'b0, 1'b0);
      idle_gap(1'b0);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (verdicts_due.size() > 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);
    if (verdicts_due.size() > 0)
      report($sformatf("%0d results never arrived", verdicts_due.size()));
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
